@@ sv/bscfc_pkg.sv @@
// ----------------------------------------------------------------------------
// bscfc_pkg
// Shared types, constants and the CRC bit update for the frame check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bscfc_pkg;

    // Frame limit and counter sizing; a frame holds up to 255 + 16 bits.
    localparam int unsigned CNT_W = 9;
    localparam logic [CNT_W-1:0] FRAME_BITS = 9'd190;

    // Check kinds as carried in the kind field.
    localparam logic KIND_CRC16 = 1'b0;
    localparam logic KIND_CRC12 = 1'b1;

    localparam logic [CNT_W-1:0] CRC16_BITS = 9'd16;
    localparam logic [CNT_W-1:0] CRC12_BITS = 9'd12;

    localparam logic [15:0] POLY16 = 16'h1021;
    localparam logic [15:0] POLY12 = 16'h0897;
    localparam logic [15:0] MASK16 = 16'hFFFF;
    localparam logic [15:0] MASK12 = 16'h0FFF;

    // Queue between the classifying front and the CRC back end.
    localparam int unsigned Q_AW = 1;
    localparam int unsigned Q_DEPTH = 1 << Q_AW;

    typedef struct packed {
        logic       data_bit;
        logic       kind;
        logic [7:0] msg_bits;
    } item_t;

    typedef struct packed {
        logic        status;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } result_t;

    // One classified frame bit as it travels through the queue.
    typedef struct packed {
        logic data_bit;
        logic kind;
        logic first;
        logic msg;
        logic last;
        logic too_long;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [15:0] kind_mask(logic kind);
        logic [15:0] m;
        m = (kind == KIND_CRC12) ? MASK12 : MASK16;
        return m;
    endfunction

    // One MSB-first shift of the CRC register.
    function automatic logic [15:0] crc_step(logic [15:0] c, logic kind, logic b);
        logic        fb;
        logic [15:0] n;
        if (kind == KIND_CRC12)
        begin
            fb = c[11] ^ b;
            n  = {4'b0000, c[10:0], 1'b0};
            if (fb)
            begin
                n = n ^ POLY12;
            end
        end
        else
        begin
            fb = c[15] ^ b;
            n  = {c[14:0], 1'b0};
            if (fb)
            begin
                n = n ^ POLY16;
            end
        end
        return n & kind_mask(kind);
    endfunction

endpackage

`default_nettype wire

@@ sv/bscfc_front.sv @@
// ----------------------------------------------------------------------------
// bscfc_front
// Accepts frame bits, tracks frame position and tags each bit for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bscfc_front
    import bscfc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  push,
    output entry_t     entry
);

    logic             in_frame_reg;
    logic             kind_reg;
    logic [7:0]       len_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             cur_kind;
    logic [7:0]       cur_len;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] cur_total;
    logic [CNT_W-1:0] cnt_inc;

    // The first beat of a frame supplies kind and length; later beats use the latch.
    always_comb
    begin
        cur_kind  = in_frame_reg ? kind_reg : item.kind;
        cur_len   = in_frame_reg ? len_reg : item.msg_bits;
        cur_cnt   = in_frame_reg ? cnt_reg : '0;
        cur_total = {1'b0, cur_len} + ((cur_kind == KIND_CRC12) ? CRC12_BITS : CRC16_BITS);
        cnt_inc   = cur_cnt + 1'b1;

        entry.data_bit = item.data_bit;
        entry.kind     = cur_kind;
        entry.first    = !in_frame_reg;
        entry.msg      = cur_cnt < {1'b0, cur_len};
        entry.last     = cnt_inc == cur_total;
        entry.too_long = cur_total > FRAME_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            kind_reg     <= KIND_CRC16;
            len_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (push)
        begin
            in_frame_reg <= !entry.last;
            kind_reg     <= cur_kind;
            len_reg      <= cur_len;
            cnt_reg      <= entry.last ? '0 : cnt_inc;
        end
    end

`ifndef SYNTHESIS
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (cnt_reg < cur_total))
        else $error("frame bit count ran past the frame end");
`endif

endmodule

`default_nettype wire

@@ sv/bscfc_queue.sv @@
// ----------------------------------------------------------------------------
// bscfc_queue
// Short register queue of classified bits between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bscfc_queue
    import bscfc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output q_status_t   status
);

    entry_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = count_reg == Q_DEPTH[Q_AW:0];
    assign status.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

@@ sv/bscfc_back.sv @@
// ----------------------------------------------------------------------------
// bscfc_back
// Runs the CRC and received-check shift registers and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bscfc_back
    import bscfc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire entry_t    head,
    input  wire q_status_t q_status,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_ready,
    output result_t        result
);

    logic        out_valid_reg;
    result_t     out_data_reg;
    logic [15:0] crc_reg;
    logic [15:0] rx_reg;

    logic [15:0] crc_base;
    logic [15:0] rx_base;
    logic [15:0] crc_next;
    logic [15:0] rx_next;
    logic [15:0] mask;
    logic [15:0] comp;
    logic [15:0] rx_masked;
    result_t     res_next;

    // The last bit of a frame may only leave the queue when the result slot frees up.
    assign pop = !q_status.empty && (!head.last || !out_valid_reg || result_ready);

    always_comb
    begin
        crc_base  = head.first ? '0 : crc_reg;
        rx_base   = head.first ? '0 : rx_reg;
        mask      = kind_mask(head.kind);
        crc_next  = head.msg ? crc_step(crc_base, head.kind, head.data_bit) : crc_base;
        rx_next   = head.msg ? rx_base : {rx_base[14:0], head.data_bit};
        comp      = (crc_next ^ mask) & mask;
        rx_masked = rx_next & mask;

        res_next.status       = (comp != rx_masked) || head.too_long;
        res_next.computed_crc = comp;
        res_next.received_crc = rx_masked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            rx_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg <= crc_next;
                rx_reg  <= rx_next;
            end
            if (pop && head.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            out_data_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !(pop && head.last))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ sv/bit_serial_crc16_crc12_frame_check_unit.sv @@
// The final check bit of a frame passes the queue slot, then the result register.
// Throughput: one frame bit per cycle while item_ready is high; the back end retires
// one queued bit a cycle unless a result waits; only then does the two-entry queue fill.
// Reset (rst_n, asynchronous, active low) clears frame tracking, queue and result valid;
// the block then waits for the first bit of a new frame.
// ----------------------------------------------------------------------------
// bit_serial_crc16_crc12_frame_check_unit
// Bit-serial CRC-16 CCITT / CRC-12 frame checker with one result per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_serial_crc16_crc12_frame_check_unit
    import bscfc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_ready,
    output result_t    result
);

    entry_t    push_entry;
    entry_t    head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    assign item_ready = !q_status.full;
    assign push       = item_valid && item_ready;

    bscfc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .push  (push),
        .entry (push_entry)
    );

    bscfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    bscfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ dv/tb_bit_serial_crc16_crc12_frame_check_unit.sv @@
// ----------------------------------------------------------------------------
// tb_bit_serial_crc16_crc12_frame_check_unit
// Self-checking bench for the bit-serial CRC-16 / CRC-12 frame checker.
// Frames are built bit by bit with good, corrupted or random check fields.
// A cycle-free model of the checker predicts each result beat, and every
// accepted result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bit_serial_crc16_crc12_frame_check_unit;
    import bscfc_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS  = 240;
    localparam int unsigned PHASE_FRAMES = 4;

    // How the check field of a generated frame is formed.
    localparam int unsigned FRAME_GOOD       = 0;
    localparam int unsigned FRAME_RANDOM_CRC = 1;
    localparam int unsigned FRAME_FLIPPED    = 2;

    // Message content of a generated frame.
    localparam int unsigned FILL_RANDOM = 0;
    localparam int unsigned FILL_ZEROS  = 1;
    localparam int unsigned FILL_ONES   = 2;

    logic    clk          = 1'b0;
    logic    rst_n;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    item_t   frame_bits_queued[$];
    result_t crc_reports_due[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    int          errors         = 0;

    // Shadow of the checker's frame state.
    logic [CNT_W-1:0] chk_count = '0;
    logic [15:0]      chk_crc   = '0;
    logic [15:0]      chk_rx    = '0;
    logic             chk_kind  = KIND_CRC16;
    logic [7:0]       chk_len   = '0;
    logic             chk_open  = 1'b0;

    bit_serial_crc16_crc12_frame_check_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    function automatic logic [15:0] crc_advance(input logic [15:0] c, input logic k,
                                                input logic b);
        logic [15:0] mask;
        logic [15:0] poly;
        logic [15:0] n;
        logic        fb;
        mask = (k == KIND_CRC12) ? MASK12 : MASK16;
        poly = (k == KIND_CRC12) ? POLY12 : POLY16;
        fb   = ((k == KIND_CRC12) ? c[11] : c[15]) ^ b;
        n    = (c << 1) & mask;
        if (fb)
        begin
            n = n ^ poly;
        end
        return n & mask;
    endfunction

    task automatic absorb_bit(input item_t it);
        logic [CNT_W-1:0] width;
        logic [CNT_W-1:0] total;
        logic [15:0]      mask;
        result_t          r;
        if (!chk_open)
        begin
            chk_kind  = it.kind;
            chk_len   = it.msg_bits;
            chk_count = '0;
            chk_crc   = '0;
            chk_rx    = '0;
            chk_open  = 1'b1;
        end
        width = (chk_kind == KIND_CRC12) ? CRC12_BITS : CRC16_BITS;
        mask  = (chk_kind == KIND_CRC12) ? MASK12 : MASK16;
        total = {1'b0, chk_len} + width;
        if (chk_count < {1'b0, chk_len})
        begin
            chk_crc = crc_advance(chk_crc, chk_kind, it.data_bit);
        end
        else
        begin
            chk_rx = {chk_rx[14:0], it.data_bit};
        end
        chk_count = chk_count + 1'b1;
        if (chk_count == total)
        begin
            r.computed_crc = ~chk_crc & mask;
            r.received_crc = chk_rx & mask;
            r.status       = (r.computed_crc != r.received_crc) || (total > FRAME_BITS);
            crc_reports_due.push_back(r);
            chk_open  = 1'b0;
            chk_count = '0;
        end
    endtask

    task automatic check_report(input result_t got);
        result_t want;
        if (crc_reports_due.size() == 0)
        begin
            $error("result beat with no frame outstanding: %h", got);
            errors++;
        end
        else
        begin
            want = crc_reports_due.pop_front();
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.computed_crc !== want.computed_crc)
            begin
                $error("computed_crc mismatch: expected %h, got %h",
                       want.computed_crc, got.computed_crc);
                errors++;
            end
            if (got.received_crc !== want.received_crc)
            begin
                $error("received_crc mismatch: expected %h, got %h",
                       want.received_crc, got.received_crc);
                errors++;
            end
        end
    endtask

    // Builds one frame and queues its bits. Only the first beat carries a
    // meaningful kind and length; the rest get random values there.
    task automatic queue_frame(input logic k, input logic [7:0] len,
                               input int unsigned flaw, input int unsigned fill);
        logic        bits [0:271];
        logic [15:0] c;
        int unsigned width;
        int unsigned total;
        int unsigned i;
        item_t       it;
        width = (k == KIND_CRC12) ? 12 : 16;
        total = len + width;
        c     = '0;
        for (i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZEROS: bits[i] = 1'b0;
                FILL_ONES:  bits[i] = 1'b1;
                default:    bits[i] = 1'($urandom_range(0, 1));
            endcase
            c = crc_advance(c, k, bits[i]);
        end
        c = ~c & ((k == KIND_CRC12) ? MASK12 : MASK16);
        for (i = 0; i < width; i++)
        begin
            bits[len + i] = c[width - 1 - i];
        end
        if (flaw == FRAME_RANDOM_CRC)
        begin
            for (i = 0; i < width; i++)
            begin
                bits[len + i] = 1'($urandom_range(0, 1));
            end
        end
        else if (flaw == FRAME_FLIPPED)
        begin
            i       = $urandom_range(0, total - 1);
            bits[i] = ~bits[i];
        end
        for (i = 0; i < total; i++)
        begin
            it.data_bit = bits[i];
            if (i == 0)
            begin
                it.kind     = k;
                it.msg_bits = len;
            end
            else
            begin
                it.kind     = 1'($urandom_range(0, 1));
                it.msg_bits = 8'($urandom_range(0, 255));
            end
            frame_bits_queued.push_back(it);
        end
    endtask

    // The sender holds off here until every frame has reported back.
    task automatic settle();
        while (frame_bits_queued.size() != 0 || item_valid || crc_reports_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                absorb_bit(item);
            end
            if (!item_valid || item_ready)
            begin
                if (frame_bits_queued.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= frame_bits_queued.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                check_report(result);
            end
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned send_pct_by_phase [4];
        int unsigned recv_pct_by_phase [4];
        int unsigned ph;
        int unsigned items;
        int unsigned frames;
        int unsigned pick;
        logic        k;
        logic [7:0]  len;
        int unsigned flaw;

        send_pct_by_phase = '{0, 63, 0, 37};
        recv_pct_by_phase = '{0, 0, 63, 37};
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty messages, where the first beat already belongs to the check field, then short ones.
        queue_frame(KIND_CRC16, 8'd0, FRAME_GOOD, FILL_RANDOM);
        queue_frame(KIND_CRC12, 8'd0, FRAME_GOOD, FILL_RANDOM);
        queue_frame(KIND_CRC16, 8'd8, FRAME_RANDOM_CRC, FILL_ZEROS);
        queue_frame(KIND_CRC12, 8'd1, FRAME_FLIPPED, FILL_ONES);
        // Longest frames that still fit, then two that do not.
        queue_frame(KIND_CRC12, 8'd178, FRAME_GOOD, FILL_RANDOM);
        queue_frame(KIND_CRC16, 8'd174, FRAME_GOOD, FILL_ONES);
        queue_frame(KIND_CRC16, 8'd175, FRAME_GOOD, FILL_RANDOM);
        queue_frame(KIND_CRC16, 8'd178, FRAME_FLIPPED, FILL_ZEROS);
        settle();

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct_by_phase[ph];
            recv_stall_pct = recv_pct_by_phase[ph];
            items  = 0;
            frames = 0;
            while (items < PHASE_ITEMS || frames < PHASE_FRAMES)
            begin
                k    = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    len = 8'($urandom_range(0, 20));
                end
                else if (pick < 95)
                begin
                    len = 8'($urandom_range(21, 100));
                end
                else
                begin
                    len = 8'($urandom_range(101, 178));
                end
                pick = $urandom_range(0, 99);
                flaw = (pick < 70) ? FRAME_GOOD :
                       (pick < 85) ? FRAME_RANDOM_CRC : FRAME_FLIPPED;
                queue_frame(k, len, flaw, FILL_RANDOM);
                items  += len + ((k == KIND_CRC12) ? 12 : 16);
                frames++;
            end
            settle();
        end

        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
